FILE: rtl/core/ellipse_label_rasterizer_macros.svh
// assertion macros shared by the checker files of the ellipse label rasterizer
// no dependencies; users include this file by its bare name

`ifndef ELLIPSE_LABEL_RASTERIZER_MACROS_SVH
`define ELLIPSE_LABEL_RASTERIZER_MACROS_SVH

// checked only while reset is low
`define ELR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ELR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/elr_pkg.sv
// types, widths and opcodes of the ellipse label rasterizer
// no dependencies; used by every module of the block

`default_nettype none

package elr_pkg;

   localparam int NUM_SLOTS    = 32;
   localparam int IMAGE_WIDTH  = 1024;
   localparam int IMAGE_HEIGHT = 1024;

   localparam int COORD_W = 10;
   localparam int SLOT_W  = 5;
   localparam int LBL_W   = 8;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int PROD_W  = 2 * SQ_W;
   localparam int ID_NEED = $clog2(NUM_SLOTS);
   localparam int ID_W    = (ID_NEED > SLOT_W) ? ID_NEED : SLOT_W;

   // request to response, in clock cycles
   localparam int LATENCY = NUM_SLOTS + 4;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] radius_x;
      logic [COORD_W-1:0] radius_y;
      logic [LBL_W-1:0]   label;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [LBL_W-1:0] pixel_label;
      logic             hit;
   } rsp_type;

   // item moving down the chain, one cell per cycle
   typedef struct packed {
      logic               vld;
      logic               op;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [SQ_W-1:0]    rx2;
      logic [SQ_W-1:0]    ry2;
      logic [PROD_W-1:0]  rr;
      logic [LBL_W-1:0]   lbl;
      logic               nz;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic               inimg;
   } fwd_type;

   // running answer, trails the item down the chain
   typedef struct packed {
      logic             cls;
      logic             inimg;
      logic [LBL_W-1:0] lbl;
      logic             hit;
   } acc_type;

endpackage

`default_nettype wire

FILE: rtl/core/elr_front.sv
// entry stages: radius squares and their product, start of the running answer
// depends on elr_pkg

`default_nettype none

module elr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire elr_pkg::req_type req,
   output elr_pkg::fwd_type     fwd_out,
   output elr_pkg::acc_type     acc_out
);
   import elr_pkg::*;

   logic            vld_ff, vld_in;
   req_type         req_ff, req_in;
   logic [SQ_W-1:0] rx2_ff, rx2_in;
   logic [SQ_W-1:0] ry2_ff, ry2_in;
   fwd_type         fwd_ff, fwd_in;
   acc_type         acc1_ff, acc1_in;
   acc_type         acc2_ff, acc2_in;

   always_comb begin
      vld_in = accept;
      req_in = req;
      rx2_in = SQ_W'(req.radius_x) * SQ_W'(req.radius_x);
      ry2_in = SQ_W'(req.radius_y) * SQ_W'(req.radius_y);
   end

   always_comb begin
      fwd_in.vld   = vld_ff && !reset;
      fwd_in.op    = req_ff.opcode;
      fwd_in.slot  = req_ff.slot;
      fwd_in.cx    = req_ff.center_x;
      fwd_in.cy    = req_ff.center_y;
      fwd_in.rx2   = rx2_ff;
      fwd_in.ry2   = ry2_ff;
      fwd_in.rr    = PROD_W'(rx2_ff) * PROD_W'(ry2_ff);
      fwd_in.lbl   = req_ff.label;
      fwd_in.nz    = (req_ff.radius_x != '0) && (req_ff.radius_y != '0);
      fwd_in.px    = req_ff.pixel_x;
      fwd_in.py    = req_ff.pixel_y;
      fwd_in.inimg = (32'(req_ff.pixel_x) < 32'(IMAGE_WIDTH)) &&
                     (32'(req_ff.pixel_y) < 32'(IMAGE_HEIGHT));
   end

   always_comb begin
      acc1_in.cls   = fwd_ff.vld && (fwd_ff.op == OP_CLASSIFY) && !reset;
      acc1_in.inimg = fwd_ff.inimg;
      acc1_in.lbl   = '0;
      acc1_in.hit   = 1'b0;
      acc2_in       = acc1_ff;
      acc2_in.cls   = acc1_ff.cls && !reset;
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rx2_ff  <= rx2_in;
      ry2_ff  <= ry2_in;
      fwd_ff  <= fwd_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign fwd_out = fwd_ff;
   assign acc_out = acc2_ff;

endmodule

`default_nettype wire

FILE: rtl/core/elr_cell.sv
// one table slot: stores an ellipse and tests passing pixels against it
// depends on elr_pkg

`default_nettype none

module elr_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [elr_pkg::ID_W-1:0] id,
   input  wire elr_pkg::fwd_type      fwd_in,
   input  wire elr_pkg::acc_type      acc_in,
   output elr_pkg::fwd_type           fwd_out,
   output elr_pkg::acc_type           acc_out
);
   import elr_pkg::*;

   // stored entry
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic [SQ_W-1:0]    rx2_ff, ry2_ff;
   logic [PROD_W-1:0]  rr_ff;
   logic [LBL_W-1:0]   lbl_ff;
   logic               use_ff;
   logic               load;

   // stage one
   logic [COORD_W-1:0] dx, dy;
   logic [SQ_W-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SQ_W-1:0]    s1_rx2_ff, s1_ry2_ff;
   logic [PROD_W-1:0]  s1_rr_ff;
   logic [LBL_W-1:0]   s1_lbl_ff;
   logic               s1_act_ff;

   // stage two
   logic [PROD_W-1:0]  px2_ff, px2_in, py2_ff, py2_in;
   logic [PROD_W-1:0]  s2_rr_ff;
   logic [LBL_W-1:0]   s2_lbl_ff;
   logic               s2_act_ff;

   logic [PROD_W:0]    lhs;
   logic               match;
   fwd_type            fwd_ff, fwd_nx_in;
   acc_type            acc_ff, acc_nx_in;

   assign load = fwd_in.vld && (fwd_in.op == OP_LOAD) && (ID_W'(fwd_in.slot) == id);

   always_comb begin
      dx     = (fwd_in.px >= cx_ff) ? (fwd_in.px - cx_ff) : (cx_ff - fwd_in.px);
      dy     = (fwd_in.py >= cy_ff) ? (fwd_in.py - cy_ff) : (cy_ff - fwd_in.py);
      sqx_in = SQ_W'(dx) * SQ_W'(dx);
      sqy_in = SQ_W'(dy) * SQ_W'(dy);
   end

   always_comb begin
      px2_in = PROD_W'(sqx_ff) * PROD_W'(s1_ry2_ff);
      py2_in = PROD_W'(sqy_ff) * PROD_W'(s1_rx2_ff);
   end

   always_comb begin
      lhs           = {1'b0, px2_ff} + {1'b0, py2_ff};
      match         = s2_act_ff && (lhs <= {1'b0, s2_rr_ff});
      acc_nx_in     = acc_in;
      acc_nx_in.cls = acc_in.cls && !reset;
      if (match) begin
         acc_nx_in.lbl = s2_lbl_ff;
         acc_nx_in.hit = 1'b1;
      end
      fwd_nx_in     = fwd_in;
      fwd_nx_in.vld = fwd_in.vld && !reset;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff  <= fwd_in.cx;
         cy_ff  <= fwd_in.cy;
         rx2_ff <= fwd_in.rx2;
         ry2_ff <= fwd_in.ry2;
         rr_ff  <= fwd_in.rr;
         lbl_ff <= fwd_in.lbl;
      end
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      s1_rx2_ff <= rx2_ff;
      s1_ry2_ff <= ry2_ff;
      s1_rr_ff  <= rr_ff;
      s1_lbl_ff <= lbl_ff;
      px2_ff    <= px2_in;
      py2_ff    <= py2_in;
      s2_rr_ff  <= s1_rr_ff;
      s2_lbl_ff <= s1_lbl_ff;
      fwd_ff    <= fwd_nx_in;
      acc_ff    <= acc_nx_in;
      if (reset) begin
         use_ff    <= 1'b0;
         s1_act_ff <= 1'b0;
         s2_act_ff <= 1'b0;
      end else begin
         if (load) begin
            use_ff <= fwd_in.nz;
         end
         s1_act_ff <= use_ff;
         s2_act_ff <= s1_act_ff;
      end
   end

   assign fwd_out = fwd_ff;
   assign acc_out = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ellipse_label_rasterizer.sv
// top level of the ellipse label rasterizer: entry stages and the chain of slot cells
// depends on elr_pkg, elr_front and elr_cell

// Takes one item per clock whenever busy is low; busy is high only during reset.
// Load and classify items travel down a chain of NUM_SLOTS cells, one cell per
// cycle, so a load is seen by every classify item that follows it. Each cell
// tests the pixel against its ellipse in three stages (distance squares, cross
// products, sum and compare), and the running answer trails the item down the
// chain. A classify item gives its result after the entry stages and all
// NUM_SLOTS cells, on rsp_item for exactly one cycle with rsp_strobe high;
// the receiver must take it then. Load items give no result.

`default_nettype none

module ellipse_label_rasterizer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire elr_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output elr_pkg::rsp_type      rsp_item
);
   import elr_pkg::*;

   fwd_type fwd_chain [NUM_SLOTS+1];
   acc_type acc_chain [NUM_SLOTS+1];
   acc_type acc_last;
   logic    accept;

   assign busy   = reset;
   assign accept = start && !busy;

   elr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_item),
      .fwd_out (fwd_chain[0]),
      .acc_out (acc_chain[0])
   );

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      elr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .id      (ID_W'(i)),
         .fwd_in  (fwd_chain[i]),
         .acc_in  (acc_chain[i]),
         .fwd_out (fwd_chain[i+1]),
         .acc_out (acc_chain[i+1])
      );
   end

   assign acc_last   = acc_chain[NUM_SLOTS];
   assign rsp_strobe = acc_last.cls;

   always_comb begin
      rsp_item.pixel_label = acc_last.inimg ? acc_last.lbl : '0;
      rsp_item.hit         = acc_last.inimg && acc_last.hit;
   end

endmodule

`default_nettype wire

FILE: rtl/core/elr_checker.sv
// port-level checks of the ellipse label rasterizer, bound to the top level
// depends on elr_pkg and ellipse_label_rasterizer_macros.svh

`default_nettype none

`include "ellipse_label_rasterizer_macros.svh"

module elr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire elr_pkg::req_type req_item,
   input wire logic             rsp_strobe,
   input wire elr_pkg::rsp_type rsp_item
);
   import elr_pkg::*;

   logic cls_accept;

   assign cls_accept = start && !busy && (req_item.opcode == OP_CLASSIFY);

   `ELR_ASSERT_ALWAYS(a_busy_in_reset, clock, reset |-> busy, "item taken during reset")
   `ELR_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_strobe, "result after reset")
   `ELR_ASSERT(a_miss_is_background, clock, reset, rsp_strobe && !rsp_item.hit |-> rsp_item.pixel_label == '0, "miss with nonzero label")
   `ELR_ASSERT(a_classify_answers, clock, reset, cls_accept |-> ##LATENCY rsp_strobe, "classify item lost")
   `ELR_ASSERT(a_result_has_cause, clock, reset, rsp_strobe |-> $past(cls_accept, LATENCY), "result without classify item")

endmodule

bind ellipse_label_rasterizer elr_checker u_elr_checker (.*);

`default_nettype wire
